/* sv/sdtx_pkg.sv */
// ----------------------------------------------------------------------------
// sdtx_pkg
// Shared types, constants and the CRC16 step for the 4-line SD data transmitter.
// ----------------------------------------------------------------------------
`default_nettype none

package sdtx_pkg;

  // Queue between the front and the back
  localparam int unsigned QUEUE_DEPTH = 4;

  // Bus and CRC geometry
  localparam int unsigned NUM_LINES = 4;
  localparam int unsigned CRC_W     = 16;
  localparam int unsigned BIT_CNT_W = 4;

  localparam logic [CRC_W-1:0] CRC_POLY  = 16'h1021;
  localparam logic [3:0]       NIB_START = 4'h0;
  localparam logic [3:0]       NIB_STOP  = 4'hF;
  localparam logic [BIT_CNT_W-1:0] CRC_MSB = 4'd15;

  typedef enum logic [1:0] {
    KIND_START = 2'd0,
    KIND_DATA  = 2'd1,
    KIND_CRC   = 2'd2,
    KIND_STOP  = 2'd3
  } nibble_kind_e;

  // Input word
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_word_t;

  // Output word
  typedef struct packed {
    logic [3:0]   bus_nibble;
    nibble_kind_e nibble_kind;
    logic         run_end;
  } out_word_t;

  // Classified byte, as queued from front to back
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
    logic       first_byte;
  } cmd_t;

  // Back-end nibble sequencer
  typedef enum logic [2:0] {
    SEQ_ITEM,
    SEQ_HI,
    SEQ_LO,
    SEQ_CRC,
    SEQ_STOP
  } seq_state_e;

  // One bit of CRC16-CCITT, MSB-first shift
  function automatic logic [CRC_W-1:0] crc_step(input logic [CRC_W-1:0] crc,
                                                input logic             din);
    logic fb;
    fb = crc[CRC_W-1] ^ din;
    crc_step = {crc[CRC_W-2:0], 1'b0} ^ (fb ? CRC_POLY : '0);
  endfunction

endpackage

`default_nettype wire

/* sv/sdtx_front.sv */
// ----------------------------------------------------------------------------
// sdtx_front
// Accepts input words, tags the first byte of each frame and pushes them
// into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module sdtx_front (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  input  sdtx_pkg::in_word_t    in_word_i,
  output logic                  in_stall_o,
  input  wire logic             q_full_i,
  output logic                  push_o,
  output sdtx_pkg::cmd_t        push_cmd_o
);
  import sdtx_pkg::*;

  logic in_frame_q, in_frame_d;

  // Stall only on a full queue
  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  // Classify: a byte seen outside a frame opens one
  assign push_cmd_o = '{data_byte:  in_word_i.data_byte,
                        last_byte:  in_word_i.last_byte,
                        first_byte: !in_frame_q};

  // Frame tracking: a last byte closes the frame
  always_comb begin
    in_frame_d = in_frame_q;
    if (push_o) begin
      in_frame_d = !in_word_i.last_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
    end else begin
      in_frame_q <= in_frame_d;
    end
  end

endmodule

`default_nettype wire

/* sv/sdtx_queue.sv */
// ----------------------------------------------------------------------------
// sdtx_queue
// Small register FIFO of classified bytes between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module sdtx_queue #(
  parameter int unsigned Depth = sdtx_pkg::QUEUE_DEPTH
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_i,
  input  sdtx_pkg::cmd_t  push_cmd_i,
  output logic            full_o,
  input  wire logic       pop_i,
  output logic            head_valid_o,
  output sdtx_pkg::cmd_t  head_cmd_o
);
  import sdtx_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  cmd_t            slot_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign full_o       = (count_q == FullCnt);
  assign head_valid_o = (count_q != '0);
  assign head_cmd_o   = slot_q[rd_ptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && head_valid_o;

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage, no reset
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

`default_nettype wire

/* sv/sdtx_back.sv */
// ----------------------------------------------------------------------------
// sdtx_back
// Nibble sequencer: start, data, per-line CRC16 and stop nibbles, one per
// cycle into the output register unless it stalls or no byte is queued.
// ----------------------------------------------------------------------------
`default_nettype none

module sdtx_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            head_valid_i,
  input  sdtx_pkg::cmd_t       head_cmd_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output sdtx_pkg::out_word_t  out_word_o
);
  import sdtx_pkg::*;

  seq_state_e state_q, state_d;
  logic [NUM_LINES-1:0][CRC_W-1:0] crc_q, crc_d;
  logic [BIT_CNT_W-1:0] bit_q, bit_d;
  logic      out_valid_q, out_valid_d;
  out_word_t out_word_q, out_word_d;

  logic      advance, emit;
  logic [3:0] hi_nib, lo_nib, crc_nib;
  logic [NUM_LINES-1:0][CRC_W-1:0] crc_hi, crc_lo;

  assign hi_nib = head_cmd_i.data_byte[7:4];
  assign lo_nib = head_cmd_i.data_byte[3:0];

  // Output register moves when empty or taken
  assign advance = !out_valid_q || !out_stall_i;
  assign emit    = advance && head_valid_i;

  // Per-line CRC after one data nibble, and the current CRC column
  always_comb begin
    for (int k = 0; k < NUM_LINES; k++) begin
      crc_hi[k]  = crc_step(crc_q[k], hi_nib[k]);
      crc_lo[k]  = crc_step(crc_q[k], lo_nib[k]);
      crc_nib[k] = crc_q[k][bit_q];
    end
  end

  // Sequencer next state and output word
  always_comb begin
    state_d    = state_q;
    crc_d      = crc_q;
    bit_d      = bit_q;
    pop_o      = 1'b0;
    out_word_d = out_word_q;
    case (state_q)
      SEQ_ITEM: begin
        if (head_cmd_i.first_byte) begin
          out_word_d = '{bus_nibble: NIB_START, nibble_kind: KIND_START, run_end: 1'b0};
          state_d    = SEQ_HI;
        end else begin
          out_word_d = '{bus_nibble: hi_nib, nibble_kind: KIND_DATA, run_end: 1'b0};
          crc_d      = crc_hi;
          state_d    = SEQ_LO;
        end
      end
      SEQ_HI: begin
        out_word_d = '{bus_nibble: hi_nib, nibble_kind: KIND_DATA, run_end: 1'b0};
        crc_d      = crc_hi;
        state_d    = SEQ_LO;
      end
      SEQ_LO: begin
        out_word_d = '{bus_nibble: lo_nib, nibble_kind: KIND_DATA,
                       run_end: !head_cmd_i.last_byte};
        crc_d      = crc_lo;
        if (head_cmd_i.last_byte) begin
          bit_d   = CRC_MSB;
          state_d = SEQ_CRC;
        end else begin
          pop_o   = emit;
          state_d = SEQ_ITEM;
        end
      end
      SEQ_CRC: begin
        out_word_d = '{bus_nibble: crc_nib, nibble_kind: KIND_CRC, run_end: 1'b0};
        bit_d      = bit_q - 1'b1;
        if (bit_q == '0) begin
          state_d = SEQ_STOP;
        end
      end
      SEQ_STOP: begin
        out_word_d = '{bus_nibble: NIB_STOP, nibble_kind: KIND_STOP, run_end: 1'b1};
        crc_d      = '0;
        pop_o      = emit;
        state_d    = SEQ_ITEM;
      end
      default: begin
        state_d = SEQ_ITEM;
      end
    endcase

    // Hold everything unless a nibble goes out this cycle
    if (!emit) begin
      state_d    = state_q;
      crc_d      = crc_q;
      bit_d      = bit_q;
      out_word_d = out_word_q;
    end

    if (emit) begin
      out_valid_d = 1'b1;
    end else if (advance) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SEQ_ITEM;
      crc_q       <= '0;
      bit_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      crc_q       <= crc_d;
      bit_q       <= bit_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output payload, no reset
  always_ff @(posedge clk_i) begin
    out_word_q <= out_word_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

`default_nettype wire

/* sv/sd_four_line_data_tx_crc16.sv */
// ----------------------------------------------------------------------------
// sd_four_line_data_tx_crc16
// Frames a byte stream onto a 4-line SD data bus with a CRC16 per line.
//
//   channel | direction | handshake              | word
//   --------+-----------+------------------------+-------------------------
//   input   | in        | in_valid_i / in_stall_o   | data_byte, last_byte
//   output  | out       | out_valid_o / out_stall_i | bus_nibble, nibble_kind,
//           |           |                        | run_end
//
// One nibble leaves per cycle unless the output stalls or no byte is queued:
// a byte's data nibbles, a start nibble before a frame's first byte, the
// per-line CRC nibbles and a stop nibble after its last. A queue of QueueDepth
// bytes sits between the input classifier and the nibble sequencer. Reset
// clears the CRCs and the frame state at once; no sweep is needed. An output
// stall holds the output word and, once the queue fills, stalls the input.
// ----------------------------------------------------------------------------
`default_nettype none

module sd_four_line_data_tx_crc16 #(
  parameter int unsigned QueueDepth = sdtx_pkg::QUEUE_DEPTH
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  input  sdtx_pkg::in_word_t   in_word_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output sdtx_pkg::out_word_t  out_word_o
);
  import sdtx_pkg::*;

  logic q_full, push, pop, head_valid;
  cmd_t push_cmd, head_cmd;

  // Input classifier
  sdtx_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_word_i  (in_word_i),
    .in_stall_o (in_stall_o),
    .q_full_i   (q_full),
    .push_o     (push),
    .push_cmd_o (push_cmd)
  );

  // Byte queue
  sdtx_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_cmd_i   (push_cmd),
    .full_o       (q_full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_cmd_o   (head_cmd)
  );

  // Nibble sequencer and CRC
  sdtx_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_cmd_i   (head_cmd),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_word_o   (out_word_o)
  );

endmodule

`default_nettype wire
